FILE: hdl/sbd_pkg.sv
// Shared types and constants for the signature base64 decoder.
// No dependencies; imported by every module of the block.
package sbd_pkg;

    // Frame layout: 86 data characters, then two pad characters
    localparam int unsigned FRAME_CHARS   = 88;
    localparam int unsigned DATA_CHARS    = 86;
    localparam int unsigned LAST_DATA_POS = 85;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned BUF_W  = 12;
    localparam int unsigned PEND_W = 4;

    localparam logic [POS_W-1:0] POS_FRAME_END = POS_W'(FRAME_CHARS);
    localparam logic [POS_W-1:0] POS_DATA_END  = POS_W'(DATA_CHARS);
    localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(LAST_DATA_POS);
    localparam logic [POS_W-1:0] POS_LAST_CHAR = POS_W'(FRAME_CHARS - 1);

    localparam logic [PEND_W-1:0] GROUP_BITS = PEND_W'(6);
    localparam logic [PEND_W-1:0] BYTE_BITS  = PEND_W'(8);

    // ASCII codes of the alphabet edges and the pad character
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // Classification of one character
    typedef struct packed {
        logic [5:0] value;  // 6-bit group, zero when not in the alphabet
        logic       alpha;  // character is in the alphabet
        logic       pad;    // character is '='
    } sextet_t;

    // One registered input beat handed to the unpacker
    typedef struct packed {
        logic       valid;
        logic [7:0] char_code;
        logic       last_char;
    } char_beat_t;

endpackage

FILE: hdl/sbd_sextet_map.sv
// Character classifier: maps an ASCII code to its base64 group value.
// Depends on sbd_pkg.
module sbd_sextet_map
    import sbd_pkg::*;
(
    input  logic [7:0] char_code,
    output sextet_t    sextet
);

    logic [7:0] ofs_upper;
    logic [7:0] ofs_lower;
    logic [7:0] ofs_digit;

    assign ofs_upper = char_code - CH_UPPER_A;
    assign ofs_lower = char_code - CH_LOWER_A + 8'd26;
    assign ofs_digit = char_code - CH_DIGIT_0 + 8'd52;

    // Decode the range the character falls in
    always_comb begin
        sextet.value = 6'd0;
        sextet.alpha = 1'b1;
        sextet.pad   = (char_code == CH_PAD);
        if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
            sextet.value = ofs_upper[5:0];
        end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
            sextet.value = ofs_lower[5:0];
        end else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9) begin
            sextet.value = ofs_digit[5:0];
        end else if (char_code == CH_PLUS) begin
            sextet.value = 6'd62;
        end else if (char_code == CH_SLASH) begin
            sextet.value = 6'd63;
        end else begin
            sextet.alpha = 1'b0;
        end
    end

endmodule

FILE: hdl/sbd_frame_unpacker.sv
// Frame state, bit packing and the result register of the decoder.
// Depends on sbd_pkg and sbd_sextet_map.
module sbd_frame_unpacker
    import sbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  char_beat_t beat,
    input  logic       advance,
    output logic       m_valid,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_frame_done,
    output logic       m_frame_ok
);

    sextet_t sextet;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [BUF_W-1:0]  buf_reg,  buf_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              err_reg,  err_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg,  byte_next;
    logic              bval_reg,  bval_next;
    logic              done_reg,  done_next;
    logic              ok_reg,    ok_next;

    logic [5:0]        group;
    logic [PEND_W-1:0] pend_add;
    logic [BUF_W-1:0]  buf_shift;

    sbd_sextet_map u_map (
        .char_code (beat.char_code),
        .sextet    (sextet)
    );

    assign group     = sextet.alpha ? sextet.value : 6'd0;
    assign pend_add  = pend_reg + GROUP_BITS;
    assign buf_shift = {buf_reg[BUF_W-7:0], group};

    // Step the frame for one character
    always_comb begin
        pos_next  = pos_reg;
        buf_next  = buf_reg;
        pend_next = pend_reg;
        err_next  = err_reg;
        byte_next = 8'd0;
        bval_next = 1'b0;
        done_next = 1'b0;
        ok_next   = 1'b0;

        if (pos_reg < POS_DATA_END) begin
            if (!sextet.alpha) begin
                err_next = 1'b1;
            end
            // Trailing bits of the last data group must be clear
            if (pos_reg == POS_LAST_DATA && group[3:0] != 4'd0) begin
                err_next = 1'b1;
            end
            buf_next = buf_shift;
            if (pend_add >= BYTE_BITS) begin
                pend_next = pend_add - BYTE_BITS;
                bval_next = 1'b1;
                case (pend_next)
                    4'd0:    byte_next = buf_shift[7:0];
                    4'd2:    byte_next = buf_shift[9:2];
                    4'd4:    byte_next = buf_shift[11:4];
                    default: byte_next = buf_shift[7:0];
                endcase
            end else begin
                pend_next = pend_add;
            end
        end else if (pos_reg < POS_FRAME_END) begin
            if (!sextet.pad) begin
                err_next = 1'b1;
            end
        end else begin
            err_next = 1'b1;
        end

        // Saturate the position at the frame length
        if (pos_reg < POS_FRAME_END) begin
            pos_next = pos_reg + POS_W'(1);
        end

        // Close the frame and return to the start
        if (beat.last_char) begin
            done_next = 1'b1;
            ok_next   = !err_next && (pos_reg == POS_LAST_CHAR);
            pos_next  = '0;
            buf_next  = '0;
            pend_next = '0;
            err_next  = 1'b0;
        end
    end

    // Result register fills whenever the sink side moves
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = beat.valid;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            buf_reg       <= '0;
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance && beat.valid) begin
                pos_reg  <= pos_next;
                buf_reg  <= buf_next;
                pend_reg <= pend_next;
                err_reg  <= err_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance && beat.valid) begin
            byte_reg <= byte_next;
            bval_reg <= bval_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_byte  = byte_reg;
    assign m_byte_valid = bval_reg;
    assign m_frame_done = done_reg;
    assign m_frame_ok   = ok_reg;

endmodule

FILE: hdl/signature_base64_decoder.sv
// Top level of the signature base64 decoder: input register and handshake.
// Depends on sbd_pkg and sbd_frame_unpacker.
//
// Decodes one padded base64 frame of 88 characters into 64 bytes.
// Input channel (s_): one character per beat in s_char_code, with
// s_last_char high on the final character of the frame.
// Result channel (m_): one result per input beat. m_byte_valid marks a beat
// that completed a byte in m_data_byte (zero otherwise). m_frame_done is high
// on the result of the last character, and m_frame_ok then gives the verdict;
// bytes of a frame with a false verdict are to be discarded.
// A character passes the input register, then the result register, before its
// result appears. Throughput: one character per cycle unless the receiver
// stalls; the classify-and-pack step between the two is combinational.
// Reset clears the frame state and empties both registers.
// When the receiver stalls, the result register holds, the input register
// fills, and s_ready drops only when both are full.
module signature_base64_decoder
    import sbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_frame_done,
    output logic       m_frame_ok
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       advance;
    char_beat_t beat;

    // Move the pipeline when the result register is free or being taken
    assign advance = !m_valid || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign beat.valid     = in_valid_reg;
    assign beat.char_code = in_char_reg;
    assign beat.last_char = in_last_reg;

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture the character on each accepted beat
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    sbd_frame_unpacker u_unpacker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat         (beat),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_data_byte  (m_data_byte),
        .m_byte_valid (m_byte_valid),
        .m_frame_done (m_frame_done),
        .m_frame_ok   (m_frame_ok)
    );

endmodule
